// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define RHD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RHD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rhd_pkg.sv -----
// Types and constants of the record header deframer.
package rhd_pkg;

    localparam logic [31:0] LEGACY_IP_RESET   = 32'h7f00_0001;
    localparam logic [15:0] LEGACY_PORT_RESET = 16'd9993;
    localparam logic [15:0] PORT_FLOOR_RESET  = 16'd1024;
    localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd16;

    localparam int unsigned POS_W = 17;

    // Byte positions within a record
    localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd4;
    localparam logic [POS_W-1:0] POS_TYPE     = 17'd5;
    localparam logic [POS_W-1:0] POS_ADDR_END = 17'd11;
    localparam logic [POS_W-1:0] START_OLD    = 17'd5;
    localparam logic [POS_W-1:0] START_NEW    = 17'd12;
    localparam logic [POS_W-1:0] HDR_TAIL     = 17'd4;

    localparam logic [15:0] MIN_RECORD_LEN = 16'd7;
    localparam logic [15:0] GREETING_LEN   = 16'd4;
    localparam logic [7:0]  TYPE_IPV4      = 8'd4;

    localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

    typedef enum logic [1:0] {
        REG_LEGACY_IP   = 2'd0,
        REG_LEGACY_PORT = 2'd1,
        REG_PORT_FLOOR  = 2'd2,
        REG_MIN_PAYLOAD = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] legacy_dest_ip;
        logic [15:0] legacy_dest_port;
        logic [15:0] port_floor;
        logic [15:0] min_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic        first_byte;
        logic        last_byte;
    } result_t;

endpackage

// ----- hdl/rhd_parser.sv -----
// Front end: per-byte record parser that classifies bytes and queues payload results.
`include "assert_macros.svh"

module rhd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                new_connection,
    input  rhd_pkg::cfg_t       cfg,
    input  logic                fifo_full,
    output logic                push,
    output rhd_pkg::result_t    push_data
);

    logic [rhd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               len_reg, len_next;
    logic                      np_reg, np_next;
    logic [47:0]               sh_reg, sh_next;
    logic                      fw_reg, fw_next;
    logic                      ap_reg, ap_next;

    // state as seen by this byte, after an optional connection restart
    logic [rhd_pkg::POS_W-1:0] p;
    logic [15:0]               len_cur;
    logic                      np_cur;
    logic [47:0]               sh_cur;
    logic                      fw_cur;
    logic                      ap_cur;

    logic [rhd_pkg::POS_W-1:0] last_pos;
    logic [rhd_pkg::POS_W-1:0] start;
    logic                      rec_end;
    logic                      emit;
    logic                      accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    assign p       = new_connection ? '0 : pos_reg;
    assign len_cur = new_connection ? '0 : len_reg;
    assign np_cur  = new_connection ? 1'b0 : np_reg;
    assign sh_cur  = new_connection ? '0 : sh_reg;
    assign fw_cur  = new_connection ? 1'b0 : fw_reg;
    assign ap_cur  = new_connection ? 1'b0 : ap_reg;

    always_comb
    begin
        len_next = len_cur;
        sh_next  = sh_cur;
        fw_next  = fw_cur;
        ap_next  = ap_cur;
        if (p == rhd_pkg::POS_LEN_HI)
        begin
            len_next = {data_byte, 8'h00};
        end
        else if (p == rhd_pkg::POS_LEN_LO)
        begin
            len_next = {len_cur[15:8], data_byte};
            if ((len_next >= rhd_pkg::MIN_RECORD_LEN) && !np_cur)
            begin
                sh_next = {cfg.legacy_dest_ip, cfg.legacy_dest_port};
                fw_next = (cfg.legacy_dest_port > cfg.port_floor) &&
                          (len_next >= cfg.min_payload);
            end
        end
        else if ((p >= rhd_pkg::POS_TYPE) && np_cur &&
                 (len_cur >= rhd_pkg::MIN_RECORD_LEN))
        begin
            if (p == rhd_pkg::POS_TYPE)
            begin
                ap_next = (data_byte == rhd_pkg::TYPE_IPV4);
                sh_next = '0;
            end
            else if ((p <= rhd_pkg::POS_ADDR_END) && ap_cur)
            begin
                sh_next = {sh_cur[39:0], data_byte};
                if (p == rhd_pkg::POS_ADDR_END)
                begin
                    fw_next = (sh_next[15:0] > cfg.port_floor) &&
                              ((len_cur - rhd_pkg::MIN_RECORD_LEN) >= cfg.min_payload);
                end
            end
        end

        last_pos = {1'b0, len_next} + rhd_pkg::HDR_TAIL;
        start    = np_cur ? rhd_pkg::START_NEW : rhd_pkg::START_OLD;
        emit     = fw_next && (p >= start) && (p <= last_pos);
        rec_end  = (p >= rhd_pkg::POS_LEN_LO) && (p == last_pos);

        np_next  = np_cur;
        pos_next = p + 1'b1;
        if (rec_end)
        begin
            if (len_next == rhd_pkg::GREETING_LEN)
            begin
                np_next = 1'b1;
            end
            pos_next = '0;
            len_next = '0;
            fw_next  = 1'b0;
            ap_next  = 1'b0;
        end
    end

    assign push                   = accept && emit;
    assign push_data.payload_byte = data_byte;
    assign push_data.dest_ip      = sh_next[47:16];
    assign push_data.dest_port    = sh_next[15:0];
    assign push_data.first_byte   = (p == start);
    assign push_data.last_byte    = (p == last_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            np_reg  <= 1'b0;
            sh_reg  <= '0;
            fw_reg  <= 1'b0;
            ap_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            np_reg  <= np_next;
            sh_reg  <= rec_end ? '0 : sh_next;
            fw_reg  <= fw_next;
            ap_reg  <= ap_next;
        end
    end

    // forwarding only ever starts on a record long enough to carry data
    `RHD_ASSERT_IMPL(a_fwd_len, fw_reg, len_reg >= rhd_pkg::MIN_RECORD_LEN, "forwarding on short record")
    // an address type is only tracked under the new protocol
    `RHD_ASSERT_IMPL(a_addr_proto, ap_reg, np_reg, "address flag without new protocol")

endmodule

// ----- hdl/rhd_fifo.sv -----
// Short result queue between the parser and the output stage.
`include "assert_macros.svh"

module rhd_fifo
#(
    parameter int unsigned DEPTH = rhd_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rhd_pkg::result_t push_data,
    input  logic             pop,
    output rhd_pkg::result_t pop_data,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rhd_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `RHD_ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
    `RHD_ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ----- hdl/rhd_out.sv -----
// Back end: output register stage that drains the result queue.
module rhd_out
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fifo_empty,
    input  rhd_pkg::result_t fifo_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rhd_pkg::result_t out_data
);

    logic             valid_reg, valid_next;
    rhd_pkg::result_t data_reg;

    // load when the stage is empty or its request is taken this cycle
    assign pop        = !fifo_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= fifo_data;
        end
    end

endmodule

// ----- hdl/record_header_deframer.sv -----
// Top level of the record header deframer: config registers, parser, queue, output stage.
//
// Takes one stream byte per cycle. Each record is a 5-byte header (bytes 3 and 4
// hold the big-endian payload length) and its payload. A record with a 4-byte
// payload is a greeting that switches the connection to the new protocol. Other
// records with a payload shorter than 7 bytes are dropped. New protocol: payload
// byte 0 must be type 4, followed by an IPv4 address and port (big-endian), then
// data. Old protocol: data goes to legacy_dest_ip/legacy_dest_port, sampled when
// the header completes. A record is forwarded only if its port exceeds port_floor
// and its data length reaches min_payload; each data byte then comes out as one
// request with destination and first/last marks. new_connection clears all parse
// state ahead of its byte. Throughput is one byte per cycle while the queue is not
// full, set by the parser update; a result is written to the queue at the edge
// that accepts its byte and is later loaded into the output register when the
// output stage is empty or its request is taken. The FIFO_DEPTH-entry queue
// absorbs output stalls; in_ready drops only while the queue is full.
// Configuration writes are taken every cycle (cfg_ready is tied high) and must
// be issued while the block is idle.
module record_header_deframer
#(
    parameter int unsigned FIFO_DEPTH = rhd_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    // byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        new_connection,

    // forwarded payload
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic [31:0] dest_ip,
    output logic [15:0] dest_port,
    output logic        first_byte,
    output logic        last_byte,

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rhd_pkg::cfg_t    cfg_reg;
    rhd_pkg::result_t push_data;
    rhd_pkg::result_t fifo_data;
    rhd_pkg::result_t out_data;
    logic             push;
    logic             pop;
    logic             fifo_full;
    logic             fifo_empty;

    assign cfg_ready = 1'b1;

    // register file; indexes follow the register map order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.legacy_dest_ip   <= rhd_pkg::LEGACY_IP_RESET;
            cfg_reg.legacy_dest_port <= rhd_pkg::LEGACY_PORT_RESET;
            cfg_reg.port_floor       <= rhd_pkg::PORT_FLOOR_RESET;
            cfg_reg.min_payload      <= rhd_pkg::MIN_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rhd_pkg::cfg_reg_t'(cfg_index))
                rhd_pkg::REG_LEGACY_IP:   cfg_reg.legacy_dest_ip   <= cfg_data;
                rhd_pkg::REG_LEGACY_PORT: cfg_reg.legacy_dest_port <= cfg_data[15:0];
                rhd_pkg::REG_PORT_FLOOR:  cfg_reg.port_floor       <= cfg_data[15:0];
                rhd_pkg::REG_MIN_PAYLOAD: cfg_reg.min_payload      <= cfg_data[15:0];
                default:                  cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // front: parse and classify each byte
    rhd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .new_connection (new_connection),
        .cfg            (cfg_reg),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_data      (push_data)
    );

    // decoupling queue
    rhd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (fifo_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // back: output register
    rhd_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (fifo_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign payload_byte = out_data.payload_byte;
    assign dest_ip      = out_data.dest_ip;
    assign dest_port    = out_data.dest_port;
    assign first_byte   = out_data.first_byte;
    assign last_byte    = out_data.last_byte;

endmodule
